FILE: sv/cfa_pkg.sv
// shared constants and register index codes for the class fraction aggregator
// no dependencies
package cfa_pkg;

    localparam int DATA_W       = 16;
    localparam int RATIO_CFG_W  = 7;
    localparam int COLS_CFG_W   = 13;
    localparam int ROWS_W       = 16;
    localparam int FRAC_W       = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int QUEUE_DEPTH  = 2;
    localparam int DEF_MAX_COLS  = 4096;
    localparam int DEF_MAX_RATIO = 64;

    localparam logic [DATA_W-1:0] NODATA_RESET = 16'hD8F1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATIO  = 3'd0,
        CFG_CLASS  = 3'd1,
        CFG_NODATA = 3'd2,
        CFG_COLS   = 3'd3,
        CFG_ROWS   = 3'd4
    } cfg_idx_t;

endpackage

FILE: sv/class_fraction_block_aggregator_core.sv
// top level of the class fraction block aggregator: front, queue and divider back part
// depends on cfa_pkg, cfa_front, cfa_fifo, cfa_back
//
// Takes one class-ID pixel per cycle in raster order, except while merging; at the last pixel
// of each block column in a row the front enters a merge state that combines the row's
// partial counts with the per-column count memory (one read and one write port) and takes
// no pixel, and at the last row of a block it stays there until the two-entry queue has
// room. A finished block waits in that queue; the back part divides with one quotient bit
// per cycle and takes the next block from the queue only after its result has been
// accepted at the output; a block with no valid pixel skips the divide. The count memory
// needs no clearing pass after reset. Configuration writes are always accepted and
// restart the grid.
module class_fraction_block_aggregator_core #(
    parameter int MAX_COLS  = cfa_pkg::DEF_MAX_COLS,
    parameter int MAX_RATIO = cfa_pkg::DEF_MAX_RATIO,
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cfa_pkg::DATA_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [cfa_pkg::DATA_W-1:0] pixel_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [cfa_pkg::FRAC_W-1:0]    fraction,
    output logic                          no_data,
    output logic [cfa_pkg::ROWS_W-1:0]    out_row,
    output logic [CW-1:0]                 out_col,
    output logic                          last
);
    import cfa_pkg::*;

    localparam int RW = (MAX_RATIO > 1) ? $clog2(MAX_RATIO) : 1;
    localparam int AW = $clog2(MAX_RATIO + 1);
    localparam int NW = $clog2(MAX_RATIO * MAX_RATIO + 1);
    localparam int EW = 2 * NW + ROWS_W + CW + 1;

    logic              f_push, f_not_full, b_pop, b_not_empty;
    logic [NW-1:0]     f_match, f_valid_cnt, b_match, b_valid_cnt;
    logic [ROWS_W-1:0] f_row, b_row;
    logic [CW-1:0]     f_col, b_col;
    logic              f_last, b_last;
    logic [EW-1:0]     push_data, pop_data;

    assign cfg_ready = 1'b1;

    cfa_front #(
        .MAX_COLS(MAX_COLS), .MAX_RATIO(MAX_RATIO), .CW(CW), .RW(RW), .AW(AW), .NW(NW)
    ) u_front (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .pixel_value(pixel_value),
        .q_push(f_push), .q_not_full(f_not_full),
        .q_match(f_match), .q_valid_cnt(f_valid_cnt),
        .q_row(f_row), .q_col(f_col), .q_last(f_last)
    );

    assign push_data = {f_match, f_valid_cnt, f_row, f_col, f_last};
    assign {b_match, b_valid_cnt, b_row, b_col, b_last} = pop_data;

    cfa_fifo #(.WIDTH(EW)) u_fifo (
        .clk(clk), .rst_n(rst_n),
        .push(f_push), .push_data(push_data), .not_full(f_not_full),
        .pop(b_pop), .not_empty(b_not_empty), .pop_data(pop_data)
    );

    cfa_back #(.CW(CW), .NW(NW)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_not_empty(b_not_empty), .q_pop(b_pop),
        .q_match(b_match), .q_valid_cnt(b_valid_cnt),
        .q_row(b_row), .q_col(b_col), .q_last(b_last),
        .out_valid(out_valid), .out_ready(out_ready),
        .fraction(fraction), .no_data(no_data),
        .out_row(out_row), .out_col(out_col), .last(last)
    );

endmodule

FILE: sv/cfa_fifo.sv
// short queue between the front and the back part
// depends on cfa_pkg for the depth
module cfa_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             not_full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);
    import cfa_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [QUEUE_DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNTW-1:0]  count_reg;
    logic             do_push, do_pop;

    assign not_full  = count_reg != CNTW'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: sv/cfa_front.sv
// front part: config registers, raster position tracking, pixel classification
// and per-column count memory; depends on cfa_pkg
module cfa_front #(
    parameter int MAX_COLS  = cfa_pkg::DEF_MAX_COLS,
    parameter int MAX_RATIO = cfa_pkg::DEF_MAX_RATIO,
    parameter int CW = 12,
    parameter int RW = 6,
    parameter int AW = 7,
    parameter int NW = 13
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [cfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cfa_pkg::DATA_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [cfa_pkg::DATA_W-1:0] pixel_value,
    output logic                          q_push,
    input  logic                          q_not_full,
    output logic [NW-1:0]                 q_match,
    output logic [NW-1:0]                 q_valid_cnt,
    output logic [cfa_pkg::ROWS_W-1:0]    q_row,
    output logic [CW-1:0]                 q_col,
    output logic                          q_last
);
    import cfa_pkg::*;

    typedef enum logic [1:0] {
        F_PIX = 2'b01,
        F_ACC = 2'b10
    } front_state_t;

    front_state_t state_reg;

    logic [RATIO_CFG_W-1:0] ratio_reg;
    logic [DATA_W-1:0]      class_reg, nodata_reg;
    logic [COLS_CFG_W-1:0]  cols_reg;
    logic [ROWS_W-1:0]      rows_reg;

    logic [ROWS_W-1:0] row_pos_reg, brow_reg;
    logic [CW-1:0]     col_pos_reg, ocol_reg;
    logic [RW-1:0]     rib_reg, cib_reg;
    logic [AW-1:0]     acc_v_reg, acc_m_reg;

    logic [AW-1:0]     hold_v_reg, hold_m_reg;
    logic [CW-1:0]     hold_col_reg;
    logic [ROWS_W-1:0] hold_row_reg;
    logic              hold_last_reg, hold_first_reg, hold_emit_reg;

    logic [2*NW-1:0]   mem [MAX_COLS];
    logic [2*NW-1:0]   rd_reg;

    logic [31:0]   ratio_ext, ratio_lim, cols_ext, cols_lim;
    logic [RW-1:0] ratio_last;
    logic [CW-1:0] cols_last;
    logic [ROWS_W-1:0] rows_last;
    logic pix_ok, pix_hit, row_end, grid_end, bce, bre, accept, mem_wr;
    logic [AW-1:0] v_sum, m_sum;
    logic [NW-1:0] tot_v, tot_m;

    always_comb
    begin
        ratio_ext = 32'(ratio_reg);
        if (ratio_ext == 32'd0)
        begin
            ratio_lim = 32'd1;
        end
        else if (ratio_ext > 32'(MAX_RATIO))
        begin
            ratio_lim = 32'(MAX_RATIO);
        end
        else
        begin
            ratio_lim = ratio_ext;
        end
        cols_ext = 32'(cols_reg);
        if (cols_ext == 32'd0)
        begin
            cols_lim = 32'd1;
        end
        else if (cols_ext > 32'(MAX_COLS))
        begin
            cols_lim = 32'(MAX_COLS);
        end
        else
        begin
            cols_lim = cols_ext;
        end
    end

    assign ratio_last = RW'(ratio_lim - 32'd1);
    assign cols_last  = CW'(cols_lim - 32'd1);
    assign rows_last  = (rows_reg == '0) ? '0 : rows_reg - 1'b1;

    assign pix_ok   = pixel_value != nodata_reg;
    assign pix_hit  = pix_ok && (pixel_value == class_reg);
    assign row_end  = col_pos_reg >= cols_last;
    assign grid_end = row_pos_reg >= rows_last;
    assign bce      = row_end || (cib_reg >= ratio_last);
    assign bre      = grid_end || (rib_reg >= ratio_last);
    assign v_sum    = acc_v_reg + AW'(pix_ok);
    assign m_sum    = acc_m_reg + AW'(pix_hit);

    assign in_ready = state_reg == F_PIX;
    assign accept   = in_valid && in_ready;

    // first row of a block row starts from zero, so the memory never needs clearing
    assign tot_v = (hold_first_reg ? '0 : rd_reg[NW-1:0]) + NW'(hold_v_reg);
    assign tot_m = (hold_first_reg ? '0 : rd_reg[2*NW-1:NW]) + NW'(hold_m_reg);

    assign q_push      = (state_reg == F_ACC) && hold_emit_reg;
    assign q_match     = tot_m;
    assign q_valid_cnt = tot_v;
    assign q_row       = hold_row_reg;
    assign q_col       = hold_col_reg;
    assign q_last      = hold_last_reg;
    assign mem_wr      = (state_reg == F_ACC) && !hold_emit_reg;

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            mem[hold_col_reg] <= {tot_m, tot_v};
        end
        // read data is held while a finished block waits for the queue
        if (state_reg == F_PIX)
        begin
            rd_reg <= mem[ocol_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && bce)
        begin
            hold_v_reg     <= v_sum;
            hold_m_reg     <= m_sum;
            hold_col_reg   <= ocol_reg;
            hold_row_reg   <= brow_reg;
            hold_last_reg  <= row_end && grid_end;
            hold_first_reg <= rib_reg == '0;
            hold_emit_reg  <= bre;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= F_PIX;
            ratio_reg   <= RATIO_CFG_W'(1);
            class_reg   <= '0;
            nodata_reg  <= NODATA_RESET;
            cols_reg    <= COLS_CFG_W'(1);
            rows_reg    <= ROWS_W'(1);
            row_pos_reg <= '0;
            brow_reg    <= '0;
            col_pos_reg <= '0;
            ocol_reg    <= '0;
            rib_reg     <= '0;
            cib_reg     <= '0;
            acc_v_reg   <= '0;
            acc_m_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RATIO:  ratio_reg  <= cfg_data[RATIO_CFG_W-1:0];
                CFG_CLASS:  class_reg  <= cfg_data;
                CFG_NODATA: nodata_reg <= cfg_data;
                CFG_COLS:   cols_reg   <= cfg_data[COLS_CFG_W-1:0];
                CFG_ROWS:   rows_reg   <= cfg_data;
                default: ;
            endcase
            // any write restarts the grid
            state_reg   <= F_PIX;
            row_pos_reg <= '0;
            brow_reg    <= '0;
            col_pos_reg <= '0;
            ocol_reg    <= '0;
            rib_reg     <= '0;
            cib_reg     <= '0;
            acc_v_reg   <= '0;
            acc_m_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                F_PIX:
                begin
                    if (accept)
                    begin
                        if (bce)
                        begin
                            acc_v_reg <= '0;
                            acc_m_reg <= '0;
                            state_reg <= F_ACC;
                        end
                        else
                        begin
                            acc_v_reg <= v_sum;
                            acc_m_reg <= m_sum;
                        end
                        if (row_end)
                        begin
                            col_pos_reg <= '0;
                            cib_reg     <= '0;
                            ocol_reg    <= '0;
                            if (grid_end)
                            begin
                                row_pos_reg <= '0;
                                rib_reg     <= '0;
                                brow_reg    <= '0;
                            end
                            else
                            begin
                                row_pos_reg <= row_pos_reg + 1'b1;
                                rib_reg     <= bre ? '0 : rib_reg + 1'b1;
                                brow_reg    <= bre ? brow_reg + 1'b1 : brow_reg;
                            end
                        end
                        else
                        begin
                            col_pos_reg <= col_pos_reg + 1'b1;
                            if (bce)
                            begin
                                cib_reg  <= '0;
                                ocol_reg <= ocol_reg + 1'b1;
                            end
                            else
                            begin
                                cib_reg <= cib_reg + 1'b1;
                            end
                        end
                    end
                end
                F_ACC:
                begin
                    if (!hold_emit_reg || q_not_full)
                    begin
                        state_reg <= F_PIX;
                    end
                end
                default: state_reg <= F_PIX;
            endcase
        end
    end

endmodule

FILE: sv/cfa_back.sv
// back part: bit-serial Q1.15 divide of match count by valid count and output register
// depends on cfa_pkg
module cfa_back #(
    parameter int CW = 12,
    parameter int NW = 13
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_not_empty,
    output logic                       q_pop,
    input  logic [NW-1:0]              q_match,
    input  logic [NW-1:0]              q_valid_cnt,
    input  logic [cfa_pkg::ROWS_W-1:0] q_row,
    input  logic [CW-1:0]              q_col,
    input  logic                       q_last,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [cfa_pkg::FRAC_W-1:0] fraction,
    output logic                       no_data,
    output logic [cfa_pkg::ROWS_W-1:0] out_row,
    output logic [CW-1:0]              out_col,
    output logic                       last
);
    import cfa_pkg::*;

    localparam int SW = $clog2(FRAC_W);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_DIV  = 3'b010,
        B_OUT  = 3'b100
    } back_state_t;

    back_state_t state_reg;

    logic [NW-1:0]     rem_reg, dvs_reg;
    logic [FRAC_W-1:0] bits_reg, quo_reg;
    logic [SW-1:0]     cnt_reg;
    logic              nd_reg, last_reg;
    logic [ROWS_W-1:0] row_reg;
    logic [CW-1:0]     col_reg;
    logic [NW:0]       trial, trial_sub;
    logic              fits;

    assign q_pop     = (state_reg == B_IDLE) && q_not_empty;
    assign trial     = {rem_reg, bits_reg[FRAC_W-1]};
    assign fits      = trial >= {1'b0, dvs_reg};
    assign trial_sub = trial - {1'b0, dvs_reg};

    assign out_valid = state_reg == B_OUT;
    assign fraction  = quo_reg;
    assign no_data   = nd_reg;
    assign out_row   = row_reg;
    assign out_col   = col_reg;
    assign last      = last_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            row_reg  <= q_row;
            col_reg  <= q_col;
            last_reg <= q_last;
            nd_reg   <= q_valid_cnt == '0;
            dvs_reg  <= q_valid_cnt;
            // match <= valid, so the top part of match << 15 is already below the divisor
            rem_reg  <= q_match >> 1;
            bits_reg <= {q_match[0], {(FRAC_W-1){1'b0}}};
            quo_reg  <= '0;
            cnt_reg  <= '0;
        end
        else if (state_reg == B_DIV)
        begin
            rem_reg  <= fits ? trial_sub[NW-1:0] : trial[NW-1:0];
            quo_reg  <= {quo_reg[FRAC_W-2:0], fits};
            bits_reg <= bits_reg << 1;
            cnt_reg  <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            case (state_reg)
                B_IDLE:
                begin
                    if (q_not_empty)
                    begin
                        state_reg <= (q_valid_cnt == '0) ? B_OUT : B_DIV;
                    end
                end
                B_DIV:
                begin
                    if (cnt_reg == SW'(FRAC_W - 1))
                    begin
                        state_reg <= B_OUT;
                    end
                end
                B_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

endmodule
